[hdl/htc_pkg.sv]
// Shared types, codes and command/status structures of the table-driven Huffman codec.
`default_nettype none
package htc_pkg;

	localparam int SYM_W  = 8;
	localparam int CODE_W = 32;
	localparam int LEN_W  = 6;
	localparam int CNT_W  = 4;
	localparam int ENT_W  = CODE_W + LEN_W;

	localparam logic [1:0] ACT_WRITE  = 2'd0;
	localparam logic [1:0] ACT_ENCODE = 2'd1;
	localparam logic [1:0] ACT_FLUSH  = 2'd2;
	localparam logic [1:0] ACT_DECODE = 2'd3;

	localparam logic [1:0] KIND_FULL = 2'd0;
	localparam logic [1:0] KIND_PART = 2'd1;
	localparam logic [1:0] KIND_SYM  = 2'd2;
	localparam logic [1:0] KIND_ERR  = 2'd3;

	localparam logic [1:0] ERR_NONE     = 2'd0;
	localparam logic [1:0] ERR_NO_CODE  = 2'd1;
	localparam logic [1:0] ERR_NO_MATCH = 2'd2;

	typedef struct packed {
		logic [1:0]       kind;
		logic [SYM_W-1:0] data;
		logic [CNT_W-1:0] filled;
		logic [1:0]       err;
	} result_t;

	typedef struct packed {
		logic load;
		logic enc_err;
		logic enc_load;
		logic enc_step;
		logic flush;
		logic dec_bit;
		logic sweep_step;
		logic dec_hit;
		logic dec_err;
		logic dec_end;
		logic finish;
	} cmd_t;

	typedef struct packed {
		logic [1:0] in_action;
		logic       in_take_zero;
		logic       usable;
		logic       enc_last;
		logic       fills;
		logic       pack_nonempty;
		logic       push_ok;
		logic       fin_ok;
		logic       hit;
		logic       done;
		logic       overlong;
		logic       issue_more;
		logic       more_bits;
	} stat_t;

endpackage
`default_nettype wire

[hdl/htc_if.sv]
// Valid/ready channel interfaces for input items and result items.
`default_nettype none
interface htc_item_if;
	logic        valid;
	logic        ready;
	logic [1:0]  action;
	logic [7:0]  symbol;
	logic [31:0] code_word;
	logic [5:0]  code_length;
	logic [7:0]  packed_byte;
	logic [3:0]  valid_bits;

	modport source(output valid, action, symbol, code_word, code_length, packed_byte,
		valid_bits, input ready);
	modport sink(input valid, action, symbol, code_word, code_length, packed_byte,
		valid_bits, output ready);
endinterface

interface htc_result_if;
	logic       valid;
	logic       ready;
	logic [1:0] out_kind;
	logic [7:0] out_byte;
	logic [3:0] filled_bits;
	logic [1:0] error_code;
	logic       last;

	modport source(output valid, out_kind, out_byte, filled_bits, error_code, last,
		input ready);
	modport sink(input valid, out_kind, out_byte, filled_bits, error_code, last,
		output ready);
endinterface
`default_nettype wire

[hdl/htc_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module htc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end
endmodule
`default_nettype wire

[hdl/htc_datapath.sv]
// Datapath: code table, bit packer, match collector, table sweep and result buffering.
`default_nettype none
module htc_datapath #(
	parameter int ALPHABET_SIZE   = 256,
	parameter int MAX_CODE_LENGTH = 32
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire htc_pkg::cmd_t             cmd,
	output      htc_pkg::stat_t            stat,
	input  wire logic [1:0]                in_action,
	input  wire logic [htc_pkg::SYM_W-1:0] in_symbol,
	input  wire logic [htc_pkg::CODE_W-1:0] in_code_word,
	input  wire logic [htc_pkg::LEN_W-1:0] in_code_length,
	input  wire logic [htc_pkg::SYM_W-1:0] in_packed_byte,
	input  wire logic [htc_pkg::CNT_W-1:0] in_valid_bits,
	output      logic                      out_valid,
	input  wire logic                      out_ready,
	output      htc_pkg::result_t          out_res,
	output      logic                      out_last
);
	import htc_pkg::*;

	localparam int AW    = $clog2(ALPHABET_SIZE);
	localparam int LIMIT = (MAX_CODE_LENGTH < 32) ? MAX_CODE_LENGTH : 32;

	logic [SYM_W-1:0]  sym_q;
	logic [SYM_W-1:0]  pbyte_q;
	logic [CNT_W-1:0]  take_q;
	logic [CNT_W-1:0]  j_q;
	logic [CODE_W-1:0] code_q;
	logic [LEN_W-1:0]  ecnt_q;
	logic [7:0]        acc_q;
	logic [2:0]        pcnt_q;
	logic [CODE_W-1:0] mbits_q;
	logic [LEN_W-1:0]  mlen_q;
	logic [AW:0]       a_q;
	logic [AW-1:0]     cidx_q;
	logic              cmp_v_q;
	logic              vld_q [ALPHABET_SIZE];
	logic              rd_vld_q;
	logic              held_v_q;
	result_t           held_q;
	logic              out_v_q;
	result_t           out_q;
	logic              out_last_q;

	logic              sym_ok;
	logic              we;
	logic              re;
	logic [AW-1:0]     raddr;
	logic [ENT_W-1:0]  rdata;
	logic [CODE_W-1:0] ent_code;
	logic [LEN_W-1:0]  ent_len;
	logic              ebit;
	logic [7:0]        acc_nx;
	logic              dbit;
	logic [CODE_W-1:0] mask;
	logic              out_free;
	logic              prod;
	result_t           res;

	assign sym_ok = 32'(in_symbol) < 32'(ALPHABET_SIZE);
	assign we     = cmd.load && (in_action == ACT_WRITE) && sym_ok;
	assign re     = cmd.load || cmd.sweep_step;
	assign raddr  = cmd.load ? in_symbol[AW-1:0] : a_q[AW-1:0];

	htc_ram #(.WIDTH(ENT_W), .DEPTH(ALPHABET_SIZE)) u_table (
		.clk   (clk),
		.we    (we),
		.waddr (in_symbol[AW-1:0]),
		.wdata ({in_code_word, in_code_length}),
		.re    (re),
		.raddr (raddr),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < ALPHABET_SIZE; i++) begin
				vld_q[i] <= 1'b0;
			end
		end else if (we) begin
			vld_q[in_symbol[AW-1:0]] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rd_vld_q <= vld_q[raddr];
		end
	end

	assign ent_code = rd_vld_q ? rdata[ENT_W-1:LEN_W] : '0;
	assign ent_len  = rd_vld_q ? rdata[LEN_W-1:0] : '0;

	assign ebit   = code_q[5'(ecnt_q - 6'd1)];
	assign acc_nx = acc_q | (8'(ebit) << (3'd7 - pcnt_q));
	assign dbit   = pbyte_q[3'(4'd7 - j_q)];
	assign mask   = 32'((33'd1 << mlen_q) - 33'd1);

	assign out_free = !out_v_q || out_ready;

	always_comb begin
		stat               = '0;
		stat.in_action     = in_action;
		stat.in_take_zero  = (in_valid_bits == '0);
		stat.usable        = (32'(sym_q) < 32'(ALPHABET_SIZE)) && (ent_len != '0)
			&& (ent_len <= LEN_W'(LIMIT));
		stat.enc_last      = (ecnt_q == 6'd1);
		stat.fills         = (pcnt_q == 3'd7);
		stat.pack_nonempty = (pcnt_q != 3'd0);
		stat.push_ok       = !held_v_q || out_free;
		stat.fin_ok        = !held_v_q || out_free;
		stat.hit           = cmp_v_q && (ent_len == mlen_q)
			&& ((ent_code & mask) == (mbits_q & mask));
		stat.done          = cmp_v_q && (cidx_q == AW'(ALPHABET_SIZE - 1)) && !stat.hit;
		stat.overlong      = mlen_q >= LEN_W'(LIMIT);
		stat.issue_more    = a_q != (AW+1)'(ALPHABET_SIZE);
		stat.more_bits     = j_q != take_q;
	end

	always_comb begin
		prod = 1'b0;
		res  = '0;
		priority if (cmd.enc_err) begin
			prod = 1'b1;
			res  = '{kind: KIND_ERR, data: '0, filled: '0, err: ERR_NO_CODE};
		end else if (cmd.enc_step && pcnt_q == 3'd7) begin
			prod = 1'b1;
			res  = '{kind: KIND_FULL, data: acc_nx, filled: 4'd8, err: ERR_NONE};
		end else if (cmd.flush) begin
			prod = 1'b1;
			res  = '{kind: KIND_PART, data: acc_q, filled: {1'b0, pcnt_q}, err: ERR_NONE};
		end else if (cmd.dec_hit) begin
			prod = 1'b1;
			res  = '{kind: KIND_SYM, data: SYM_W'(cidx_q), filled: '0, err: ERR_NONE};
		end else if (cmd.dec_err) begin
			prod = 1'b1;
			res  = '{kind: KIND_ERR, data: '0, filled: '0, err: ERR_NO_MATCH};
		end else begin
			prod = 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			sym_q   <= in_symbol;
			pbyte_q <= in_packed_byte;
			take_q  <= (in_valid_bits > 4'd8) ? 4'd8 : in_valid_bits;
			j_q     <= '0;
		end
		if (cmd.enc_load) begin
			code_q <= ent_code;
			ecnt_q <= ent_len;
		end else if (cmd.enc_step) begin
			ecnt_q <= ecnt_q - 6'd1;
		end
		if (cmd.dec_bit) begin
			j_q <= j_q + 4'd1;
			a_q <= '0;
		end else if (cmd.sweep_step) begin
			a_q    <= a_q + 1'b1;
			cidx_q <= a_q[AW-1:0];
		end
		if (prod) begin
			held_q <= res;
		end
		if (prod && held_v_q) begin
			out_q      <= held_q;
			out_last_q <= 1'b0;
		end else if (cmd.finish && held_v_q) begin
			out_q      <= held_q;
			out_last_q <= 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q    <= '0;
			pcnt_q   <= '0;
			mbits_q  <= '0;
			mlen_q   <= '0;
			cmp_v_q  <= 1'b0;
			held_v_q <= 1'b0;
			out_v_q  <= 1'b0;
		end else begin
			if (cmd.enc_step) begin
				if (pcnt_q == 3'd7) begin
					acc_q  <= '0;
					pcnt_q <= '0;
				end else begin
					acc_q  <= acc_nx;
					pcnt_q <= pcnt_q + 3'd1;
				end
			end else if (cmd.flush) begin
				acc_q  <= '0;
				pcnt_q <= '0;
			end
			if (cmd.dec_bit) begin
				mbits_q <= {mbits_q[CODE_W-2:0], dbit};
				mlen_q  <= mlen_q + 6'd1;
			end else if (cmd.dec_hit || cmd.dec_err) begin
				mbits_q <= '0;
				mlen_q  <= '0;
			end
			if (cmd.dec_bit || cmd.dec_hit || cmd.dec_end) begin
				cmp_v_q <= 1'b0;
			end else if (cmd.sweep_step) begin
				cmp_v_q <= 1'b1;
			end
			if (prod) begin
				held_v_q <= 1'b1;
			end else if (cmd.finish) begin
				held_v_q <= 1'b0;
			end
			if ((prod || cmd.finish) && held_v_q) begin
				out_v_q <= 1'b1;
			end else if (out_ready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_v_q;
	assign out_res   = out_q;
	assign out_last  = out_last_q;
endmodule
`default_nettype wire

[hdl/htc_ctrl.sv]
// Controller state machine that sequences table writes, encoding, flushing and decoding.
`default_nettype none
module htc_ctrl (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           item_valid,
	output      logic           item_ready,
	input  wire htc_pkg::stat_t stat,
	output      htc_pkg::cmd_t  cmd
);
	import htc_pkg::*;

	typedef enum logic [6:0] {
		ST_IDLE    = 7'b0000001,
		ST_ENC_RD  = 7'b0000010,
		ST_ENC_BIT = 7'b0000100,
		ST_FLUSH   = 7'b0001000,
		ST_DEC_BIT = 7'b0010000,
		ST_SWEEP   = 7'b0100000,
		ST_FIN     = 7'b1000000
	} state_t;

	state_t st_q;
	state_t st_nx;

	always_comb begin
		cmd        = '0;
		st_nx      = st_q;
		item_ready = 1'b0;
		unique case (st_q)
			ST_IDLE: begin
				item_ready = 1'b1;
				if (item_valid) begin
					cmd.load = 1'b1;
					unique case (stat.in_action)
						ACT_WRITE:  st_nx = ST_IDLE;
						ACT_ENCODE: st_nx = ST_ENC_RD;
						ACT_FLUSH:  st_nx = ST_FLUSH;
						default:    st_nx = stat.in_take_zero ? ST_FIN : ST_DEC_BIT;
					endcase
				end
			end
			ST_ENC_RD: begin
				if (stat.usable) begin
					cmd.enc_load = 1'b1;
					st_nx        = ST_ENC_BIT;
				end else if (stat.push_ok) begin
					cmd.enc_err = 1'b1;
					st_nx       = ST_FIN;
				end
			end
			ST_ENC_BIT: begin
				if (!stat.fills || stat.push_ok) begin
					cmd.enc_step = 1'b1;
					if (stat.enc_last) begin
						st_nx = ST_FIN;
					end
				end
			end
			ST_FLUSH: begin
				if (!stat.pack_nonempty) begin
					st_nx = ST_FIN;
				end else if (stat.push_ok) begin
					cmd.flush = 1'b1;
					st_nx     = ST_FIN;
				end
			end
			ST_DEC_BIT: begin
				cmd.dec_bit = 1'b1;
				st_nx       = ST_SWEEP;
			end
			ST_SWEEP: begin
				priority if (stat.hit) begin
					if (stat.push_ok) begin
						cmd.dec_hit = 1'b1;
						st_nx       = stat.more_bits ? ST_DEC_BIT : ST_FIN;
					end
				end else if (stat.done) begin
					if (!stat.overlong) begin
						cmd.dec_end = 1'b1;
						st_nx       = stat.more_bits ? ST_DEC_BIT : ST_FIN;
					end else if (stat.push_ok) begin
						cmd.dec_err = 1'b1;
						cmd.dec_end = 1'b1;
						st_nx       = stat.more_bits ? ST_DEC_BIT : ST_FIN;
					end
				end else if (stat.issue_more) begin
					cmd.sweep_step = 1'b1;
				end else begin
					st_nx = ST_SWEEP;
				end
			end
			ST_FIN: begin
				if (stat.fin_ok) begin
					cmd.finish = 1'b1;
					st_nx      = ST_IDLE;
				end
			end
			default: st_nx = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
		end else begin
			st_q <= st_nx;
		end
	end
endmodule
`default_nettype wire

[hdl/huffman_table_codec.sv]
// Top level of the table-driven Huffman codec.
// A table write is done in idle. An encode reads the symbol's table entry, then packs its
// code bits in turn; a flush emits any partly filled byte. A decode collects its valid bits in
// turn, and every collected bit is matched by a sweep over the code table RAM, one entry a
// cycle through its single read port; the lowest matching symbol ends the sweep early.
// Results pass through a holding register and an output register, so a stalled result channel
// holds the block only once two results are waiting.
`default_nettype none
module huffman_table_codec #(
	parameter int ALPHABET_SIZE   = 256,
	parameter int MAX_CODE_LENGTH = 32
) (
	input wire logic   clk,
	input wire logic   arst_n,
	htc_item_if.sink   item,
	htc_result_if.source result
);
	import htc_pkg::*;

	cmd_t    cmd;
	stat_t   stat;
	result_t res;

	htc_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item.valid),
		.item_ready (item.ready),
		.stat       (stat),
		.cmd        (cmd)
	);

	htc_datapath #(
		.ALPHABET_SIZE   (ALPHABET_SIZE),
		.MAX_CODE_LENGTH (MAX_CODE_LENGTH)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.stat           (stat),
		.in_action      (item.action),
		.in_symbol      (item.symbol),
		.in_code_word   (item.code_word),
		.in_code_length (item.code_length),
		.in_packed_byte (item.packed_byte),
		.in_valid_bits  (item.valid_bits),
		.out_valid      (result.valid),
		.out_ready      (result.ready),
		.out_res        (res),
		.out_last       (result.last)
	);

	assign result.out_kind    = res.kind;
	assign result.out_byte    = res.data;
	assign result.filled_bits = res.filled;
	assign result.error_code  = res.err;
endmodule
`default_nettype wire

[hdl/htc_checker.sv]
// Port-level checker for the codec and the bind that attaches it to the top level.
`default_nettype none
module htc_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       item_ready,
	input wire logic       res_valid,
	input wire logic       res_ready,
	input wire logic [1:0] res_kind,
	input wire logic [7:0] res_byte,
	input wire logic [3:0] res_filled,
	input wire logic [1:0] res_err,
	input wire logic       res_last
);
	import htc_pkg::*;

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res_byte) && $stable(res_kind))
		else $error("result beat changed while stalled");

	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_last |-> !item_ready)
		else $error("new item taken before the last result of the previous one");

	a_err: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> ((res_kind == KIND_ERR) == (res_err != ERR_NONE)))
		else $error("error code disagrees with result kind");

	a_fill: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && (res_kind == KIND_SYM || res_kind == KIND_ERR) |-> res_filled == 4'd0)
		else $error("fill count set on a symbol or error beat");

	a_full: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_kind == KIND_FULL |-> res_filled == 4'd8)
		else $error("full byte without eight filled bits");
endmodule

bind huffman_table_codec htc_checker u_htc_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.item_ready (item.ready),
	.res_valid  (result.valid),
	.res_ready  (result.ready),
	.res_kind   (result.out_kind),
	.res_byte   (result.out_byte),
	.res_filled (result.filled_bits),
	.res_err    (result.error_code),
	.res_last   (result.last)
);
`default_nettype wire
